// ----- hdl/swu_pkg.sv -----
`default_nettype none

package swu_pkg;

	// count width and derived sizes
	localparam int COUNT_WIDTH   = 32;
	localparam int COUNT_VALUE_W = 32;
	localparam int PERIOD_W      = 16;
	localparam int ACCUM_W       = 32;
	localparam int NUM_DIGITS    = 10;
	localparam int BIT_CNT_W     = $clog2(COUNT_WIDTH + 1);
	localparam int DIG_IDX_W     = $clog2(NUM_DIGITS);
	localparam int REM_W         = $clog2(NUM_DIGITS + 1);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
	localparam logic [PERIOD_W-1:0] MS_MAX       = '1;

	// ascii codes
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		MODE_STOP  = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic {
		TX_IDLE,
		TX_SEND
	} tx_state_t;

	// architectural state of the watch
	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count;
		mode_t                  mode;
		logic [PERIOD_W-1:0]    ms_elapsed;
		logic [ACCUM_W-1:0]     rx_accum;
		logic                   rx_active;
	} sw_state_t;

	// one loop pass as received
	typedef struct packed {
		logic       ms_tick;
		logic       run_stop_pressed;
		logic       clear_pressed;
		logic       left_pressed;
		logic       right_pressed;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       report_on;
	} pass_in_t;

	// start of byte emission for one pass
	typedef struct packed {
		logic                   go;
		logic                   left;
		logic                   right;
		logic                   report;
		logic [COUNT_WIDTH-1:0] count;
		mode_t                  mode;
	} tx_start_t;

	typedef struct packed {
		logic start;
		logic next;
	} bcd_ctrl_t;

	typedef struct packed {
		logic       done;
		logic [3:0] digit;
		logic       last;
	} bcd_stat_t;

	typedef struct packed {
		logic left;
		logic right;
		logic n;
		logic dig;
		logic nl;
		logic empty;
	} tx_pend_t;

endpackage

`default_nettype wire

// ----- hdl/swu_step.sv -----
`default_nettype none

module swu_step (
	input  swu_pkg::sw_state_t               cur,
	input  logic [swu_pkg::PERIOD_W-1:0]     period,
	input  swu_pkg::pass_in_t                pin,
	output swu_pkg::sw_state_t               nxt
);
	import swu_pkg::*;

	logic [PERIOD_W-1:0]    ms;
	logic [COUNT_WIDTH-1:0] cnt;
	mode_t                  md;
	logic [ACCUM_W-1:0]     acc;
	logic                   act;
	logic [ACCUM_W-1:0]     acc_x10;

	assign acc_x10 = (cur.rx_accum << 3) + (cur.rx_accum << 1);

	// timing, button and command stages of one pass
	always_comb begin
		ms  = cur.ms_elapsed;
		cnt = cur.count;
		md  = cur.mode;
		acc = cur.rx_accum;
		act = cur.rx_active;

		// timing
		if (pin.ms_tick && ms != MS_MAX) begin
			ms = ms + PERIOD_W'(1);
		end
		if (ms >= period) begin
			ms = '0;
			if (md == MODE_RUN) begin
				cnt = cnt + COUNT_WIDTH'(1);
			end
		end

		// buttons
		if (pin.clear_pressed) begin
			md = MODE_CLEAR;
		end else begin
			case (md)
				MODE_RUN: begin
					if (pin.run_stop_pressed) begin
						md = MODE_STOP;
					end
				end
				MODE_CLEAR: begin
					md  = MODE_STOP;
					cnt = '0;
				end
				default: begin
					// stop, and the unused code behaves as stop
					md = pin.run_stop_pressed ? MODE_RUN : MODE_STOP;
				end
			endcase
		end

		// received command
		if (pin.rx_valid) begin
			case (pin.rx_byte)
				CH_T: begin
					md  = (md == MODE_RUN) ? MODE_STOP : MODE_RUN;
					act = 1'b0;
				end
				CH_C: begin
					md  = MODE_CLEAR;
					act = 1'b0;
				end
				CH_N: begin
					acc = '0;
					act = 1'b1;
				end
				CH_NL: begin
					if (act) begin
						cnt = acc[COUNT_WIDTH-1:0];
						act = 1'b0;
					end
				end
				default: begin
					if (act && (pin.rx_byte inside {[CH_ZERO:CH_NINE]})) begin
						acc = acc_x10 + ACCUM_W'(pin.rx_byte - CH_ZERO);
					end
				end
			endcase
		end

		nxt.count      = cnt;
		nxt.mode       = md;
		nxt.ms_elapsed = ms;
		nxt.rx_accum   = acc;
		nxt.rx_active  = act;
	end

endmodule

`default_nettype wire

// ----- hdl/swu_bcd.sv -----
`default_nettype none

module swu_bcd (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swu_pkg::bcd_ctrl_t              ctrl,
	input  logic [swu_pkg::COUNT_WIDTH-1:0] value,
	output swu_pkg::bcd_stat_t              stat
);
	import swu_pkg::*;

	logic [COUNT_WIDTH-1:0] bin_q;
	logic [3:0]             dig_q [NUM_DIGITS];
	logic [3:0]             adj   [NUM_DIGITS];
	logic [3:0]             dig_n [NUM_DIGITS];
	logic [BIT_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   rdy_q;
	logic [REM_W-1:0]       rem_q;
	logic [REM_W-1:0]       nd;
	logic [DIG_IDX_W-1:0]   rd_idx;

	// add-3 correction and one-bit shift of the decimal digits
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
		dig_n[0] = {adj[0][2:0], bin_q[COUNT_WIDTH-1]};
		for (int i = 1; i < NUM_DIGITS; i++) begin
			dig_n[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	// significant digit count, at least one
	always_comb begin
		nd = REM_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (dig_q[i] != 4'd0) begin
				nd = REM_W'(i + 1);
			end
		end
	end

	// conversion and digit countdown control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			rdy_q  <= 1'b0;
			rem_q  <= '0;
		end else if (ctrl.start) begin
			cnt_q  <= BIT_CNT_W'(COUNT_WIDTH);
			busy_q <= 1'b1;
			rdy_q  <= 1'b0;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - BIT_CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
				rdy_q  <= 1'b1;
				rem_q  <= nd;
			end
		end else if (ctrl.next && rem_q != '0) begin
			rem_q <= rem_q - REM_W'(1);
			if (rem_q == REM_W'(1)) begin
				rdy_q <= 1'b0;
			end
		end
	end

	// shift registers for binary input and decimal digits
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			bin_q <= value;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				dig_q[i] <= 4'd0;
			end
		end else if (busy_q && cnt_q != '0) begin
			bin_q <= bin_q << 1;
			for (int i = 0; i < NUM_DIGITS; i++) begin
				dig_q[i] <= dig_n[i];
			end
		end
	end

	// most significant remaining digit first
	assign rd_idx      = DIG_IDX_W'(rem_q - REM_W'(1));
	assign stat.done   = rdy_q && (rem_q != '0);
	assign stat.digit  = (rem_q != '0) ? dig_q[rd_idx] : 4'd0;
	assign stat.last   = (rem_q == REM_W'(1));

endmodule

`default_nettype wire

// ----- hdl/swu_tx.sv -----
`default_nettype none

module swu_tx (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swu_pkg::tx_start_t                start,
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        tx_byte,
	output logic                              tx_valid,
	output logic                              last,
	output logic [swu_pkg::COUNT_VALUE_W-1:0] count_value,
	output logic [1:0]                        mode
);
	import swu_pkg::*;

	tx_state_t              state_q;
	tx_state_t              state_nx;
	tx_pend_t               pend_q;
	tx_pend_t               pend_nx;
	logic [COUNT_WIDTH-1:0] cnt_snap_q;
	mode_t                  mode_snap_q;
	bcd_ctrl_t              bcd_ctrl;
	bcd_stat_t              bcd_stat;

	logic       have;
	logic       is_digit;
	logic [7:0] sel_byte;
	logic       sel_txv;
	logic       sel_last;
	logic       load_ok;
	logic       emit;

	logic                     out_valid_q;
	logic [7:0]               byte_q;
	logic                     txv_q;
	logic                     last_q;
	logic [COUNT_VALUE_W-1:0] cv_q;
	logic [1:0]               mode_q;

	swu_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bcd_ctrl),
		.value  (start.count),
		.stat   (bcd_stat)
	);

	assign load_ok        = !out_valid_q || out_ready;
	assign emit           = (state_q == TX_SEND) && have && load_ok;
	assign bcd_ctrl.start = (state_q == TX_IDLE) && start.go && start.report;
	assign bcd_ctrl.next  = emit && is_digit;
	assign busy           = (state_q != TX_IDLE);

	// next byte of the pass in order: echoes, then report text
	always_comb begin
		have     = 1'b0;
		is_digit = 1'b0;
		sel_byte = 8'h00;
		sel_txv  = 1'b1;
		sel_last = 1'b0;
		pend_nx  = pend_q;
		if (pend_q.left) begin
			have         = 1'b1;
			sel_byte     = CH_T;
			sel_last     = !pend_q.right && !pend_q.n;
			pend_nx.left = 1'b0;
		end else if (pend_q.right) begin
			have          = 1'b1;
			sel_byte      = CH_C;
			sel_last      = !pend_q.n;
			pend_nx.right = 1'b0;
		end else if (pend_q.n) begin
			have      = 1'b1;
			sel_byte  = CH_N;
			pend_nx.n = 1'b0;
		end else if (pend_q.dig) begin
			if (bcd_stat.done) begin
				have        = 1'b1;
				is_digit    = 1'b1;
				sel_byte    = CH_ZERO | {4'd0, bcd_stat.digit};
				pend_nx.dig = !bcd_stat.last;
			end
		end else if (pend_q.nl) begin
			have       = 1'b1;
			sel_byte   = CH_NL;
			sel_last   = 1'b1;
			pend_nx.nl = 1'b0;
		end else if (pend_q.empty) begin
			have          = 1'b1;
			sel_txv       = 1'b0;
			sel_last      = 1'b1;
			pend_nx.empty = 1'b0;
		end
	end

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			TX_IDLE: begin
				if (start.go) begin
					state_nx = TX_SEND;
				end
			end
			TX_SEND: begin
				if (emit && sel_last) begin
					state_nx = TX_IDLE;
				end
			end
			default: begin
				state_nx = TX_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TX_IDLE;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == TX_IDLE && start.go) begin
				pend_q.left  <= start.left;
				pend_q.right <= start.right;
				pend_q.n     <= start.report;
				pend_q.dig   <= start.report;
				pend_q.nl    <= start.report;
				pend_q.empty <= !start.left && !start.right && !start.report;
			end else if (emit) begin
				pend_q <= pend_nx;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pass snapshot and output register payload
	always_ff @(posedge clk) begin
		if (state_q == TX_IDLE && start.go) begin
			cnt_snap_q  <= start.count;
			mode_snap_q <= start.mode;
		end
		if (emit) begin
			byte_q <= sel_byte;
			txv_q  <= sel_txv;
			last_q <= sel_last;
			cv_q   <= COUNT_VALUE_W'(cnt_snap_q);
			mode_q <= mode_snap_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_byte     = byte_q;
	assign tx_valid    = txv_q;
	assign last        = last_q;
	assign count_value = cv_q;
	assign mode        = mode_q;

endmodule

`default_nettype wire

// ----- hdl/stopwatch_uart_controller.sv -----
// Stopwatch with a serial command interface, one loop pass per input transfer.
// Input channel (in_valid/in_ready) carries the pass flags and an optional
// received byte. Output channel (out_valid/out_ready) returns one transfer per
// byte to send (T/C echoes, then N, decimal count, newline when report_on),
// or a single transfer with tx_valid low when nothing is sent; last marks the
// final one. count_value and mode show the state at the end of the pass.
// period_ms is to be written through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this.
// A report runs a bit-serial binary to decimal converter, one count bit per
// cycle, then gives one digit per cycle while the receiver is ready.
// in_ready is low while a pass is being emitted; a stalled receiver holds the
// output register and the emission simply waits, nothing is dropped.
// Reset clears the count, stop mode, the tick counter and number entry, and
// sets period_ms to 100.
`default_nettype none

module stopwatch_uart_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [swu_pkg::PERIOD_W-1:0]      cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              ms_tick,
	input  logic                              run_stop_pressed,
	input  logic                              clear_pressed,
	input  logic                              left_pressed,
	input  logic                              right_pressed,
	input  logic                              rx_valid,
	input  logic [7:0]                        rx_byte,
	input  logic                              report_on,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        tx_byte,
	output logic                              tx_valid,
	output logic                              last,
	output logic [swu_pkg::COUNT_VALUE_W-1:0] count_value,
	output logic [1:0]                        mode
);
	import swu_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	sw_state_t           st_q;
	sw_state_t           st_nx;
	pass_in_t            pin;
	tx_start_t           txs;
	logic                tx_busy;
	logic                accept;

	assign pin.ms_tick          = ms_tick;
	assign pin.run_stop_pressed = run_stop_pressed;
	assign pin.clear_pressed    = clear_pressed;
	assign pin.left_pressed     = left_pressed;
	assign pin.right_pressed    = right_pressed;
	assign pin.rx_valid         = rx_valid;
	assign pin.rx_byte          = rx_byte;
	assign pin.report_on        = report_on;

	assign in_ready = !tx_busy;
	assign accept   = in_valid && in_ready;

	swu_step u_step (
		.cur    (st_q),
		.period (period_q),
		.pin    (pin),
		.nxt    (st_nx)
	);

	// hand the updated state and pass flags to the byte sequencer
	assign txs.go     = accept;
	assign txs.left   = left_pressed;
	assign txs.right  = right_pressed;
	assign txs.report = report_on;
	assign txs.count  = st_nx.count;
	assign txs.mode   = st_nx.mode;

	swu_tx u_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (txs),
		.busy        (tx_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tx_byte     (tx_byte),
		.tx_valid    (tx_valid),
		.last        (last),
		.count_value (count_value),
		.mode        (mode)
	);

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			period_q <= cfg_wr_data;
		end
	end

	// watch state, updated once per input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.count      <= '0;
			st_q.mode       <= MODE_STOP;
			st_q.ms_elapsed <= '0;
			st_q.rx_accum   <= '0;
			st_q.rx_active  <= 1'b0;
		end else if (accept) begin
			st_q <= st_nx;
		end
	end

endmodule

`default_nettype wire
